// ===== rtl/mpqa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpqa_pkg: shared types and constants of the min-priority queue
// Payload structs, command and status codes, and the cell control struct.
// ----------------------------------------------------------------------------
package mpqa_pkg;

   localparam int DEPTH     = 16;
   localparam int COUNT_W   = $clog2(DEPTH + 1);
   localparam int CAP_W     = 5;
   localparam int VALUE_W   = 32;
   localparam int STATUS_W  = 2;
   localparam int ENTRY_W   = 5;
   localparam int LIM_W     = (COUNT_W > CAP_W) ? COUNT_W : CAP_W;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   localparam logic CMD_ENQ = 1'b0;
   localparam logic CMD_DEQ = 1'b1;

   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic                      cmd;
      logic signed [VALUE_W-1:0] push_value;
   } req_payload_type;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic signed [VALUE_W-1:0] popped_value;
      logic [ENTRY_W-1:0]        entry_count;
   } rsp_payload_type;

   typedef struct packed {
      logic insert;
      logic remove;
   } cell_ctrl_type;

endpackage

// ===== rtl/mpqa_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpqa_cell: one slot of the sorted cell chain
// Holds one value. On insert it keeps its value, takes the new value, or
// takes its left neighbor's value; on remove it takes its right neighbor's.
// ----------------------------------------------------------------------------
module mpqa_cell (
   input  logic                               clock,
   input  mpqa_pkg::cell_ctrl_type            ctrl_i,
   input  logic                               occupied_i,
   input  logic signed [mpqa_pkg::VALUE_W-1:0] new_value_i,
   input  logic signed [mpqa_pkg::VALUE_W-1:0] left_value_i,
   input  logic                               left_yield_i,
   input  logic signed [mpqa_pkg::VALUE_W-1:0] right_value_i,
   output logic signed [mpqa_pkg::VALUE_W-1:0] value_o,
   output logic                               yield_o
);

   logic signed [mpqa_pkg::VALUE_W-1:0] value_ff;
   logic signed [mpqa_pkg::VALUE_W-1:0] value_in;

   // The cell gives way when it is empty or the new value sorts strictly before it,
   // so equal values stay behind the older copies.
   assign yield_o = !occupied_i || (new_value_i < value_ff);
   assign value_o = value_ff;

   always_comb begin
      value_in = value_ff;
      if (ctrl_i.remove) begin
         value_in = right_value_i;
      end else if (ctrl_i.insert) begin
         if (left_yield_i) begin
            value_in = left_value_i;
         end else if (yield_o) begin
            value_in = new_value_i;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

// ===== rtl/min_priority_queue_array.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_priority_queue_array: bounded min-priority queue on a chain of cells
// Commands are registered, then executed by the sorted chain.
// ----------------------------------------------------------------------------
// The command is held in the staging register and executed by the chain; the
// result is then registered onto rsp_valid and rsp_payload.
// Throughput: one command per cycle; busy stays low, and the chain of sorted
// cells finishes an insert or a removal without stalling.
// Reset: clears the entry count and any command in flight and sets the
// capacity to 16; stored cell values are not cleared.
module min_priority_queue_array (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  mpqa_pkg::req_payload_type        req_payload,
   output logic                             rsp_valid,
   output mpqa_pkg::rsp_payload_type        rsp_payload,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [mpqa_pkg::CAP_W-1:0]       csr_data
);

   localparam int N = mpqa_pkg::DEPTH;

   logic                               stg_valid_ff;
   logic                               stg_valid_in;
   mpqa_pkg::req_payload_type          stg_payload_ff;
   logic [mpqa_pkg::COUNT_W-1:0]       count_ff;
   logic [mpqa_pkg::COUNT_W-1:0]       count_in;
   logic [mpqa_pkg::CAP_W-1:0]         cap_ff;
   logic                               rsp_valid_ff;
   mpqa_pkg::rsp_payload_type          rsp_payload_ff;
   mpqa_pkg::rsp_payload_type          rsp_payload_in;

   mpqa_pkg::cell_ctrl_type            cell_ctrl;
   logic                               is_enq;
   logic                               is_full;
   logic                               is_empty;
   logic signed [mpqa_pkg::VALUE_W-1:0] cell_value [N];
   logic                               cell_yield [N];
   logic                               cell_occ   [N];

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign stg_valid_in = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
      end
      if (stg_valid_in) begin
         stg_payload_ff <= req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= mpqa_pkg::CAP_RESET;
      end else if (csr_valid && csr_ready) begin
         cap_ff <= csr_data;
      end
   end

   // Execute stage decisions.
   assign is_enq   = (stg_payload_ff.cmd == mpqa_pkg::CMD_ENQ);
   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff >= mpqa_pkg::COUNT_W'(N)) ||
                     (mpqa_pkg::LIM_W'(count_ff) >= mpqa_pkg::LIM_W'(cap_ff));

   assign cell_ctrl.insert = stg_valid_ff && is_enq && !is_full;
   assign cell_ctrl.remove = stg_valid_ff && !is_enq && !is_empty;

   always_comb begin
      count_in = count_ff;
      if (cell_ctrl.insert) begin
         count_in = count_ff + 1'b1;
      end else if (cell_ctrl.remove) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_comb begin
      rsp_payload_in.status       = mpqa_pkg::ST_DONE;
      rsp_payload_in.popped_value = '0;
      rsp_payload_in.entry_count  = mpqa_pkg::ENTRY_W'(count_in);
      if (is_enq) begin
         if (is_full) begin
            rsp_payload_in.status = mpqa_pkg::ST_FULL;
         end
      end else if (is_empty) begin
         rsp_payload_in.status = mpqa_pkg::ST_EMPTY;
      end else begin
         // The head cell always holds the smallest stored value.
         rsp_payload_in.popped_value = cell_value[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= stg_valid_ff;
      end
      if (stg_valid_ff) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   for (genvar i = 0; i < N; i++) begin : g_cell
      localparam logic [mpqa_pkg::COUNT_W-1:0] IDX = mpqa_pkg::COUNT_W'(i);
      logic signed [mpqa_pkg::VALUE_W-1:0] left_value;
      logic                                left_yield;
      logic signed [mpqa_pkg::VALUE_W-1:0] right_value;

      assign cell_occ[i] = (IDX < count_ff);

      if (i == 0) begin : g_head
         assign left_value = '0;
         assign left_yield = 1'b0;
      end else begin : g_body
         assign left_value = cell_value[i-1];
         assign left_yield = cell_yield[i-1];
      end

      if (i == N - 1) begin : g_tail
         assign right_value = cell_value[i];
      end else begin : g_mid
         assign right_value = cell_value[i+1];
      end

      mpqa_cell u_cell (
         .clock         (clock),
         .ctrl_i        (cell_ctrl),
         .occupied_i    (cell_occ[i]),
         .new_value_i   (stg_payload_ff.push_value),
         .left_value_i  (left_value),
         .left_yield_i  (left_yield),
         .right_value_i (right_value),
         .value_o       (cell_value[i]),
         .yield_o       (cell_yield[i])
      );
   end

endmodule

// ===== rtl/mpqa_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpqa_checker: port-level checks of the min-priority queue
// Watches command transfers and result strobes on the top-level ports.
// ----------------------------------------------------------------------------
module mpqa_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      start,
   input logic                      busy,
   input mpqa_pkg::rsp_payload_type rsp_payload,
   input logic                      rsp_valid
);

   // Every command transfer produces a result.
   a_rsp_follows_cmd: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_valid)
      else $error("command transfer without a result");

   // No result appears without an earlier command transfer.
   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("result without a command transfer");

   // A dropped enqueue never returns a value.
   a_full_no_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status == mpqa_pkg::ST_FULL)
         |-> (rsp_payload.popped_value == '0))
      else $error("full status with a nonzero value");

   // An empty report leaves the queue empty and returns zero.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status == mpqa_pkg::ST_EMPTY)
         |-> (rsp_payload.entry_count == '0 && rsp_payload.popped_value == '0))
      else $error("empty status with entries or a value");

endmodule

bind min_priority_queue_array mpqa_checker u_mpqa_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .rsp_payload (rsp_payload),
   .rsp_valid   (rsp_valid)
);
